@@ hdl/sfc_pkg.sv @@
// Shared types, constants and the arctangent table of the sphere culling block.
`default_nettype none
package sfc_pkg;

  localparam int CoordW   = 32;
  localparam int AxisW    = 48;
  localparam int CompW    = 16;
  localparam int FovW     = 14;
  localparam int RadW     = 31;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = DiffW + CompW;
  localparam int DotW     = ProdW + 2;
  localparam int ClassW   = DotW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = AxisW;

  localparam int CordW    = DotW + 2;
  localparam int AngW     = 16;
  localparam int AngOutW  = AngW - 1;
  localparam int QuoW     = 16;
  localparam int DivSteps = QuoW + 1;
  localparam int DvsW     = DotW;
  localparam int RemW     = DvsW + DivSteps;
  localparam int MarginShift = 27;

  localparam int QueueDepth = 4;

  localparam int AnglePi     = 25736;
  localparam int AngleHalfPi = 12868;
  localparam int MarginMax   = 32767;
  localparam int FarInt      = 150;
  localparam int FarShift    = 30;
  localparam int RadShift    = 14;

  localparam logic [FovW-1:0] VfovReset = 14'd4289;
  localparam logic [FovW-1:0] HfovReset = 14'd7094;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_FORWARD_AXIS,
    REG_RIGHT_AXIS,
    REG_UP_AXIS,
    REG_HALF_VFOV,
    REG_HALF_HFOV
  } cfg_reg_t;

  typedef struct packed {
    logic                   reject;
    logic signed [DotW-1:0] fwd;
    logic signed [DotW-1:0] rgt;
    logic signed [DotW-1:0] up;
    logic [RadW-1:0]        radius;
  } cull_item_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned i);
    logic signed [AngW-1:0] v;
    unique case (i)
      0:       v = 16'sd6434;
      1:       v = 16'sd3798;
      2:       v = 16'sd2007;
      3:       v = 16'sd1019;
      4:       v = 16'sd511;
      5:       v = 16'sd256;
      6:       v = 16'sd128;
      7:       v = 16'sd64;
      8:       v = 16'sd32;
      9:       v = 16'sd16;
      10:      v = 16'sd8;
      11:      v = 16'sd4;
      12:      v = 16'sd2;
      13:      v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sfc_front.sv @@
// Front end: takes spheres, projects them onto the camera axes and flags near/far rejects.
`default_nettype none
module sfc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_x,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_y,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_z,
  input  logic [sfc_pkg::RadW-1:0]            sphere_radius,
  input  logic signed [sfc_pkg::CoordW-1:0]   camera_x,
  input  logic signed [sfc_pkg::CoordW-1:0]   camera_y,
  input  logic signed [sfc_pkg::CoordW-1:0]   camera_z,
  input  logic [sfc_pkg::AxisW-1:0]           forward_axis,
  input  logic [sfc_pkg::AxisW-1:0]           right_axis,
  input  logic [sfc_pkg::AxisW-1:0]           up_axis,
  input  logic                                q_full,
  output logic                                push,
  output sfc_pkg::cull_item_t                 item
);
  import sfc_pkg::*;

  localparam logic signed [ClassW-1:0] FarQ30 = ClassW'(FarInt) << FarShift;

  logic [3:0] vld;
  logic       adv;

  logic signed [CoordW-1:0] sph [3];
  logic signed [CoordW-1:0] cam [3];
  logic [AxisW-1:0]         axes [3];

  logic signed [DiffW-1:0] diff [3];
  logic [RadW-1:0]         rad1;
  logic signed [ProdW-1:0] prod [3][3];
  logic [RadW-1:0]         rad2;
  logic signed [DotW-1:0]  dot [3];
  logic [RadW-1:0]         rad3;

  logic signed [ClassW-1:0] fwd_ext;
  logic signed [ClassW-1:0] rad_ext;
  logic                     reject;

  assign sph[0] = sphere_x;
  assign sph[1] = sphere_y;
  assign sph[2] = sphere_z;
  assign cam[0] = camera_x;
  assign cam[1] = camera_y;
  assign cam[2] = camera_z;
  assign axes[0] = forward_axis;
  assign axes[1] = right_axis;
  assign axes[2] = up_axis;

  assign adv      = !vld[3] || !q_full;
  assign in_ready = adv;
  assign push     = vld[3] && !q_full;

  assign fwd_ext = ClassW'(dot[0]);
  assign rad_ext = $signed({(ClassW - RadW - RadShift)'(0), rad3, RadShift'(0)});
  assign reject  = (fwd_ext < -rad_ext) || (fwd_ext > FarQ30 + rad_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        diff[k] <= DiffW'(sph[k]) - DiffW'(cam[k]);
      end
      rad1 <= sphere_radius;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= ProdW'(diff[k]) * ProdW'($signed(axes[a][CompW*k +: CompW]));
        end
      end
      rad2 <= rad1;
      for (int a = 0; a < 3; a++) begin
        dot[a] <= DotW'(prod[a][0]) + DotW'(prod[a][1]) + DotW'(prod[a][2]);
      end
      rad3 <= rad2;
      item.reject <= reject;
      item.fwd    <= dot[0];
      item.rgt    <= dot[1];
      item.up     <= dot[2];
      item.radius <= rad3;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted request did not enter the front pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && q_full) |=> $stable(item) && vld[3])
    else $error("front result changed while the queue was full");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !push) |-> q_full)
    else $error("front result held back without a full queue");

endmodule
`default_nettype wire

@@ hdl/sfc_queue.sv @@
// Small queue that decouples the front end from the angle and margin back end.
`default_nettype none
module sfc_queue #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfc_pkg::cull_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sfc_pkg::cull_item_t head_item
);
  import sfc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cull_item_t      mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("request popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count beyond its depth");

endmodule
`default_nettype wire

@@ hdl/sfc_back.sv @@
// Back end: CORDIC angle pipelines, margin divider pipeline and the final field-of-view test.
`default_nettype none
module sfc_back #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  sfc_pkg::cull_item_t           head_item,
  output logic                          pop,
  input  logic [sfc_pkg::FovW-1:0]      half_vertical_fov,
  input  logic [sfc_pkg::FovW-1:0]      half_horizontal_fov,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible
);
  import sfc_pkg::*;

  localparam int Steps = (CORDIC_STAGES > DivSteps) ? CORDIC_STAGES : DivSteps;
  localparam int CmpW  = AngW + 2;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DvsW-1:0] dvs;
    logic [QuoW-1:0] quo;
    logic            sat;
  } div_t;

  typedef struct packed {
    logic reject;
    logic fneg;
    logic fzero;
    logic zero_h;
    logic zero_v;
  } flag_t;

  function automatic rot_t cordic_step(input rot_t r, input int unsigned i);
    rot_t n;
    n = r;
    if (r.y > 0) begin
      n.x = r.x + (r.y >>> i);
      n.y = r.y - (r.x >>> i);
      n.z = r.z + atan_entry(i);
    end else begin
      n.x = r.x - (r.y >>> i);
      n.y = r.y + (r.x >>> i);
      n.z = r.z - atan_entry(i);
    end
    return n;
  endfunction

  function automatic div_t div_step(input div_t d, input int unsigned sh);
    div_t            n;
    logic [RemW-1:0] part;
    n    = d;
    part = RemW'(d.dvs) << sh;
    if (d.rem >= part) begin
      if (sh == DivSteps - 1) begin
        n.sat = 1'b1;
      end else begin
        n.rem = d.rem - part;
        n.quo[4'(sh)] = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [AngOutW-1:0] fold_angle(input rot_t r, input logic zero,
                                                    input logic fneg);
    logic [AngOutW-1:0] m;
    logic [AngOutW-1:0] a;
    if (r.z < 0) begin
      m = '0;
    end else if (r.z > AngW'(AngleHalfPi)) begin
      m = AngOutW'(AngleHalfPi);
    end else begin
      m = r.z[AngOutW-1:0];
    end
    if (zero) begin
      a = fneg ? AngOutW'(AnglePi) : '0;
    end else begin
      a = fneg ? AngOutW'(AnglePi) - m : m;
    end
    return a;
  endfunction

  logic              adv;
  logic [Steps:0]    vld;
  rot_t              ch [0:Steps];
  rot_t              cv [0:Steps];
  div_t              dv [0:Steps];
  flag_t             fl [0:Steps];

  logic [DotW-1:0]   abs_f;
  logic [DotW-1:0]   abs_r;
  logic [DotW-1:0]   abs_u;

  logic                    p1_valid;
  logic                    p1_reject;
  logic [AngOutW-1:0]      ah;
  logic [AngOutW-1:0]      av;
  logic signed [AngW-1:0]  margin;
  logic [AngOutW-1:0]      mag;
  logic signed [AngW-1:0]  margin_next;
  logic                    vis_next;

  assign adv = !out_valid || out_ready;
  assign pop = head_valid && adv;

  assign abs_f = head_item.fwd[DotW-1] ? DotW'(-head_item.fwd) : DotW'(head_item.fwd);
  assign abs_r = head_item.rgt[DotW-1] ? DotW'(-head_item.rgt) : DotW'(head_item.rgt);
  assign abs_u = head_item.up[DotW-1]  ? DotW'(-head_item.up)  : DotW'(head_item.up);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[Steps-1:0], pop};
      p1_valid  <= vld[Steps];
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch[0].x     <= CordW'(abs_f);
      ch[0].y     <= CordW'(abs_r);
      ch[0].z     <= '0;
      cv[0].x     <= CordW'(abs_f);
      cv[0].y     <= CordW'(abs_u);
      cv[0].z     <= '0;
      dv[0].rem   <= RemW'(head_item.radius) << MarginShift;
      dv[0].dvs   <= abs_f;
      dv[0].quo   <= '0;
      dv[0].sat   <= 1'b0;
      fl[0].reject <= head_item.reject;
      fl[0].fneg   <= head_item.fwd[DotW-1];
      fl[0].fzero  <= (head_item.fwd == '0);
      fl[0].zero_h <= (head_item.rgt == '0);
      fl[0].zero_v <= (head_item.up == '0);
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    rot_t ch_n;
    rot_t cv_n;
    div_t dv_n;

    if (k < CORDIC_STAGES) begin : g_rot
      assign ch_n = cordic_step(ch[k], k);
      assign cv_n = cordic_step(cv[k], k);
    end else begin : g_rot_hold
      assign ch_n = ch[k];
      assign cv_n = cv[k];
    end

    if (k < DivSteps) begin : g_div
      assign dv_n = div_step(dv[k], DivSteps - 1 - k);
    end else begin : g_div_hold
      assign dv_n = dv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ch[k+1] <= ch_n;
        cv[k+1] <= cv_n;
        dv[k+1] <= dv_n;
        fl[k+1] <= fl[k];
      end
    end
  end

  always_comb begin
    if (fl[Steps].fzero || dv[Steps].sat || dv[Steps].quo[QuoW-1]) begin
      mag = AngOutW'(MarginMax);
    end else begin
      mag = dv[Steps].quo[AngOutW-1:0];
    end
    if (fl[Steps].fneg) begin
      margin_next = -$signed({1'b0, mag});
    end else begin
      margin_next = $signed({1'b0, mag});
    end
  end

  assign vis_next = !p1_reject &&
    ($signed({3'b0, ah}) <= $signed({4'b0, half_horizontal_fov}) + CmpW'(margin)) &&
    ($signed({3'b0, av}) <= $signed({4'b0, half_vertical_fov}) + CmpW'(margin));

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_reject <= fl[Steps].reject;
      ah        <= fold_angle(ch[Steps], fl[Steps].zero_h, fl[Steps].fneg);
      av        <= fold_angle(cv[Steps], fl[Steps].zero_v, fl[Steps].fneg);
      margin    <= margin_next;
      visible   <= vis_next;
    end
  end

  a_reject_hidden: assert property (@(posedge clk) disable iff (rst)
    (adv && p1_valid && p1_reject) |=> !visible)
    else $error("rejected sphere reported visible");

  a_zero_margin: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[Steps] && fl[Steps].fzero) |=> margin == AngW'(MarginMax))
    else $error("zero forward distance did not give the maximum margin");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> (ah <= AngOutW'(AnglePi)) && (av <= AngOutW'(AnglePi)))
    else $error("angle beyond pi");

endmodule
`default_nettype wire

@@ hdl/sphere_frustum_cull.sv @@
// Top level of the sphere culling block: configuration registers and the front, queue and back.
// The block takes one sphere per clock unless stalled and answers one visible bit per sphere,
// in order. A sphere passes through the projection front end and the queue, then through the
// back end, whose length is set by the longer of the CORDIC angle pipelines and the 17-step
// restoring divider that forms the radius over distance margin; with no stalls the throughput
// is one request per cycle.
`default_nettype none
module sphere_frustum_cull #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sfc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [sfc_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_x,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_y,
  input  logic signed [sfc_pkg::CoordW-1:0]   sphere_z,
  input  logic [sfc_pkg::RadW-1:0]            sphere_radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                visible
);
  import sfc_pkg::*;

  logic signed [CoordW-1:0] camera_x;
  logic signed [CoordW-1:0] camera_y;
  logic signed [CoordW-1:0] camera_z;
  logic [AxisW-1:0]         forward_axis;
  logic [AxisW-1:0]         right_axis;
  logic [AxisW-1:0]         up_axis;
  logic [FovW-1:0]          half_vertical_fov;
  logic [FovW-1:0]          half_horizontal_fov;

  logic       push;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  cull_item_t push_item;
  cull_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x            <= '0;
      camera_y            <= '0;
      camera_z            <= '0;
      forward_axis        <= '0;
      right_axis          <= '0;
      up_axis             <= '0;
      half_vertical_fov   <= VfovReset;
      half_horizontal_fov <= HfovReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X:     camera_x            <= cfg_data[CoordW-1:0];
        REG_CAMERA_Y:     camera_y            <= cfg_data[CoordW-1:0];
        REG_CAMERA_Z:     camera_z            <= cfg_data[CoordW-1:0];
        REG_FORWARD_AXIS: forward_axis        <= cfg_data[AxisW-1:0];
        REG_RIGHT_AXIS:   right_axis          <= cfg_data[AxisW-1:0];
        REG_UP_AXIS:      up_axis             <= cfg_data[AxisW-1:0];
        REG_HALF_VFOV:    half_vertical_fov   <= cfg_data[FovW-1:0];
        REG_HALF_HFOV:    half_horizontal_fov <= cfg_data[FovW-1:0];
      endcase
    end
  end

  sfc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sphere_x      (sphere_x),
    .sphere_y      (sphere_y),
    .sphere_z      (sphere_z),
    .sphere_radius (sphere_radius),
    .camera_x      (camera_x),
    .camera_y      (camera_y),
    .camera_z      (camera_z),
    .forward_axis  (forward_axis),
    .right_axis    (right_axis),
    .up_axis       (up_axis),
    .q_full        (q_full),
    .push          (push),
    .item          (push_item)
  );

  sfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sfc_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (pop),
    .half_vertical_fov   (half_vertical_fov),
    .half_horizontal_fov (half_horizontal_fov),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .visible             (visible)
  );

endmodule
`default_nettype wire

@@ verif/tb_sphere_frustum_cull.sv @@
// Self-checking testbench for the sphere culling block with a built-in visibility predictor.
`default_nettype none
module tb_sphere_frustum_cull;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages = 14;
  localparam int Latency = 9 + 17;
  localparam int WatchdogLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] sphere_x = '0;
  logic signed [CoordW-1:0] sphere_y = '0;
  logic signed [CoordW-1:0] sphere_z = '0;
  logic [RadW-1:0] sphere_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic visible;

  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [47:0] fwd_axis, rgt_axis, up_vec;
  logic [13:0] vfov_half, hfov_half;

  bit expected_visible[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rand_stall = 1'b1;

  sphere_frustum_cull #(.CORDIC_STAGES(Stages)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint dot_q30(longint dx, longint dy, longint dz, logic [47:0] ax);
    longint cx, cy, cz;
    cx = longint'($signed(ax[15:0]));
    cy = longint'($signed(ax[31:16]));
    cz = longint'($signed(ax[47:32]));
    return dx * cx + dy * cy + dz * cz;
  endfunction

  function automatic int angle_mag(longint p, longint f);
    longint x, y, xs, ys;
    int z;
    x = (f < 0) ? -f : f;
    y = (p < 0) ? -p : p;
    z = 0;
    if (y == 0) return (f < 0) ? AnglePi : 0;
    for (int i = 0; i < Stages && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z += int'(atan_entry(i));
      end else begin
        x = x - ys;
        y = y + xs;
        z -= int'(atan_entry(i));
      end
    end
    if (z < 0) z = 0;
    if (z > AngleHalfPi) z = AngleHalfPi;
    return (f < 0) ? AnglePi - z : z;
  endfunction

  function automatic bit predict_visible(logic signed [31:0] sx, logic signed [31:0] sy,
                                         logic signed [31:0] sz, logic [30:0] r);
    longint dx, dy, dz, f, pr, pu, rad, margin;
    int ah, av;
    dx = longint'(sx) - longint'(cam_x);
    dy = longint'(sy) - longint'(cam_y);
    dz = longint'(sz) - longint'(cam_z);
    rad = longint'({33'd0, r});
    f = dot_q30(dx, dy, dz, fwd_axis);
    if (f < -(rad * 16384) || f > (longint'(150) << 30) + rad * 16384) return 1'b0;
    pr = dot_q30(dx, dy, dz, rgt_axis);
    pu = dot_q30(dx, dy, dz, up_vec);
    ah = angle_mag(pr, f);
    av = angle_mag(pu, f);
    if (f == 0) margin = MarginMax;
    else begin
      margin = (rad * (longint'(1) << 27)) / f;
      if (margin > MarginMax) margin = MarginMax;
      if (margin < -MarginMax) margin = -MarginMax;
    end
    return (longint'(ah) <= longint'(hfov_half) + margin) &&
           (longint'(av) <= longint'(vfov_half) + margin);
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    case (idx)
      REG_CAMERA_X: cam_x = value[31:0];
      REG_CAMERA_Y: cam_y = value[31:0];
      REG_CAMERA_Z: cam_z = value[31:0];
      REG_FORWARD_AXIS: fwd_axis = value;
      REG_RIGHT_AXIS: rgt_axis = value;
      REG_UP_AXIS: up_vec = value;
      REG_HALF_VFOV: vfov_half = value[13:0];
      default: hfov_half = value[13:0];
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_visible.size() != 0) @(negedge clk);
    wait_cycles(Latency + 4);
  endtask

  task automatic send_sphere(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] sz, logic [30:0] r);
    int gap;
    gap = rand_stall ? int'($urandom_range(0, 8)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid <= 1'b1;
    sphere_x <= sx;
    sphere_y <= sy;
    sphere_z <= sz;
    sphere_radius <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_visible.push_back(predict_visible(sx, sy, sz, r));
    @(negedge clk);
  endtask

  function automatic logic [47:0] pack_axis(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 65536 * 4));
      1: return 31'($urandom() & 32'h7fffffff);
      default: return 31'($urandom_range(0, 65536 * 40));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $signed($urandom_range(0, 65536 * 400)) - 65536 * 200;
  endfunction

  task automatic set_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [47:0] f, logic [47:0] r, logic [47:0] u,
                            logic [13:0] v, logic [13:0] h);
    write_reg(REG_CAMERA_X, {16'd0, x});
    write_reg(REG_CAMERA_Y, {16'd0, y});
    write_reg(REG_CAMERA_Z, {16'd0, z});
    write_reg(REG_FORWARD_AXIS, f);
    write_reg(REG_RIGHT_AXIS, r);
    write_reg(REG_UP_AXIS, u);
    write_reg(REG_HALF_VFOV, {34'd0, v});
    write_reg(REG_HALF_HFOV, {34'd0, h});
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_values;
    send_sphere(32'sd0, 32'sd0, 32'sd0, 31'd0);
    send_sphere(32'sh7fffffff, -32'sh80000000, 32'sd65536, 31'h7fffffff);
    drain();
  endtask

  task automatic test_directed;
    set_camera(0, 0, 0, pack_axis(0, 0, 16384), pack_axis(16384, 0, 0),
               pack_axis(0, 16384, 0), 14'd4289, 14'd7094);
    send_sphere(0, 0, 65536 * 10, 31'd65536);
    send_sphere(0, 0, 0, 31'd0);
    send_sphere(0, 0, -65536 * 5, 31'd65536);
    send_sphere(0, 0, -65536 * 5, 31'd65536 * 6);
    send_sphere(0, 0, 65536 * 151, 31'd65536);
    send_sphere(0, 0, 65536 * 150, 31'd0);
    send_sphere(65536 * 50, 0, 65536 * 10, 31'd65536);
    send_sphere(0, -65536 * 50, 65536 * 10, 31'd65536);
    send_sphere(65536 * 50, 0, -65536, 31'h7fffffff);
    send_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
    send_sphere(-32'sh80000000, -32'sh80000000, -32'sh80000000, 31'd0);
    send_sphere(65536 * 3, 65536 * 3, 65536 * 10, 31'd0);
    drain();
    set_camera(32'h80000000, 32'h7fffffff, 32'hffff0000, pack_axis(-32768, 32767, -1),
               pack_axis(32767, -32768, 0), pack_axis(-1, 0, 32767), 14'd0, 14'd16383);
    send_sphere(0, 0, 0, 31'd0);
    send_sphere(32'sh7fffffff, -32'sh80000000, 0, 31'h7fffffff);
    send_sphere(-32'sh80000000, 32'sh7fffffff, 65536, 31'd1);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    int u, s, c;
    for (int p = 0; p < phases; p++) begin
      rand_stall = (p % 4) != 3;
      if (p % 5 == 4) begin
        set_camera($urandom(), $urandom(), $urandom(), 48'({$urandom(), $urandom()}),
                   48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                   14'($urandom()), 14'($urandom()));
      end else begin
        u = int'($urandom_range(0, 2));
        s = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
        c = $urandom_range(0, 1) ? 16384 : -16384;
        set_camera(rand_coord(), rand_coord(), rand_coord(),
                   pack_axis(u == 0 ? s : 0, u == 1 ? s : 0, u == 2 ? s : 0),
                   pack_axis(u == 1 ? c : 0, u == 2 ? c : 0, u == 0 ? c : 0),
                   pack_axis(u == 2 ? c : 0, u == 0 ? c : 0, u == 1 ? c : 0),
                   14'($urandom_range(0, 12868)), 14'($urandom_range(0, 16383)));
      end
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_sphere($urandom(), $urandom(), $urandom(), 31'($urandom()));
        else
          send_sphere(cam_x + rand_coord(), cam_y + rand_coord(), cam_z + rand_coord(),
                      rand_radius());
      end
      drain();
    end
    rand_stall = 1'b1;
  endtask

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = rand_stall ? int'($urandom_range(0, 8)) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_visible.size() == 0) begin
        $display("%0t: unexpected result visible=%0b", $time, visible);
        errors++;
      end else begin
        bit exp_vis;
        exp_vis = expected_visible.pop_front();
        if (visible !== exp_vis) begin
          $display("%0t: visible mismatch expected %0b actual %0b", $time, exp_vis, visible);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[sphere_frustum_cull] ERROR");
      $finish;
    end
  end

  initial begin
    cam_x = 0;
    cam_y = 0;
    cam_z = 0;
    fwd_axis = 0;
    rgt_axis = 0;
    up_vec = 0;
    vfov_half = 14'd4289;
    hfov_half = 14'd7094;
    wait_cycles(8);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_values();
    test_directed();
    test_random(25, 50);
    drain();
    if (expected_visible.size() == 0 && errors == 0) begin
      $display("[sphere_frustum_cull] OK");
    end else begin
      $display("[sphere_frustum_cull] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
